@@ sv/psi_pkg.sv @@
`timescale 1ns / 1ps
// psi_pkg: constants and types for the power series inverse core
// depends on nothing; used by psi_mulmod, psi_cell and the top level
package psi_pkg;

    localparam int unsigned DW = 30;
    localparam int unsigned CNT_W = 7;

    localparam logic [DW-1:0] PRIME = 30'd998244353;
    // 2^30 mod prime, used to fold the wide coefficient
    localparam logic [DW-1:0] RADIX_RES = 30'd75497471;
    // fermat exponent prime - 2
    localparam logic [DW-1:0] INV_EXP = 30'd998244351;
    // barrett constant floor(2^60 / prime)
    localparam logic [30:0] BARRETT_MU = 31'((64'd1 << 60) / 64'd998244353);

    typedef logic [DW-1:0] elem_t;

    typedef struct packed {
        logic a_shift;
        logic b_fwd;
        logic b_bwd;
    } cell_ctl_t;

endpackage

@@ sv/psi_mulmod.sv @@
`timescale 1ns / 1ps
// psi_mulmod: pipelined (a*b + c) mod prime with barrett reduction
// depends on psi_pkg
module psi_mulmod
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  psi_pkg::elem_t a,
    input  psi_pkg::elem_t b,
    input  psi_pkg::elem_t c,
    output logic           out_valid,
    output psi_pkg::elem_t result
);

    logic [59:0]    p1_reg;
    logic [61:0]    q2_reg;
    logic [31:0]    p2_reg;
    logic [31:0]    r3_reg;
    psi_pkg::elem_t out_reg;
    logic [3:0]     vld_reg;

    logic [30:0]    q3;
    logic [31:0]    qp_lo;
    logic [31:0]    two_p;
    logic [31:0]    r_fix;

    assign q3    = q2_reg[61:31];
    assign qp_lo = 32'(61'(q3) * 61'(psi_pkg::PRIME));
    assign two_p = {1'b0, psi_pkg::PRIME, 1'b0};

    always_comb
    begin
        if (r3_reg >= two_p)
        begin
            r_fix = r3_reg - two_p;
        end
        else if (r3_reg >= 32'(psi_pkg::PRIME))
        begin
            r_fix = r3_reg - 32'(psi_pkg::PRIME);
        end
        else
        begin
            r_fix = r3_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        p1_reg  <= 60'(a) * 60'(b) + 60'(c);
        q2_reg  <= 62'(p1_reg[59:29]) * 62'(psi_pkg::BARRETT_MU);
        p2_reg  <= p1_reg[31:0];
        r3_reg  <= p2_reg - qp_lo;
        out_reg <= r_fix[psi_pkg::DW-1:0];
    end

    assign out_valid = vld_reg[3];
    assign result    = out_reg;

endmodule

@@ sv/psi_cell.sv @@
`timescale 1ns / 1ps
// psi_cell: one cell of the coefficient chain, holds one series and one inverse term
// depends on psi_pkg
module psi_cell
(
    input  logic                clk,
    input  psi_pkg::cell_ctl_t  ctl,
    input  psi_pkg::elem_t      a_in,
    input  psi_pkg::elem_t      b_fwd_in,
    input  psi_pkg::elem_t      b_bwd_in,
    input  logic                b_wr,
    input  psi_pkg::elem_t      b_wr_data,
    output psi_pkg::elem_t      a_out,
    output psi_pkg::elem_t      b_out
);

    psi_pkg::elem_t a_reg;
    psi_pkg::elem_t b_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.a_shift)
        begin
            a_reg <= a_in;
        end
        if (b_wr)
        begin
            b_reg <= b_wr_data;
        end
        else if (ctl.b_fwd)
        begin
            b_reg <= b_fwd_in;
        end
        else if (ctl.b_bwd)
        begin
            b_reg <= b_bwd_in;
        end
    end

    assign a_out = a_reg;
    assign b_out = b_reg;

endmodule

@@ sv/power_series_inverse_mod_prime_core.sv @@
`timescale 1ns / 1ps
// power_series_inverse_mod_prime_core: reciprocal of a power series mod 998244353
// depends on psi_pkg, psi_cell, psi_mulmod
//
// channel   ports                                        transaction
// input     start, busy, coefficient, series_end         start && !busy
// result    result_valid, inverse_coefficient, run_end,  result_valid (one cycle)
//           status
// config    cfg_valid, cfg_ready, cfg_data               cfg_valid && cfg_ready
//
// an ordinary coefficient takes two passes through the 4-stage modular
// multiplier, which fold it to 30 bits
// a series end zero-fills the chain to MAX_TERMS entries, computes the inverse of
// a0 (30 squarings and 28 multiplies), then runs n-1 chain passes, each of which
// drains the products still in the multiplier before its final multiply, and then
// reads the n results out
// results leave one per cycle and the receiver cannot stall them
// reset clears control state only; the chain contents need no reset
module power_series_inverse_mod_prime_core
#(
    parameter int unsigned MAX_TERMS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] coefficient,
    input  logic        series_end,
    output logic        result_valid,
    output logic [29:0] inverse_coefficient,
    output logic        run_end,
    output logic        status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data
);

    localparam int unsigned IW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int unsigned CW = psi_pkg::CNT_W;

    typedef enum logic [4:0] {
        S_IDLE, S_RED, S_REDW, S_LOAD, S_PAD, S_CHK,
        S_INV_SQ, S_INV_SQW, S_INV_ML, S_INV_MLW,
        S_ALIGN, S_ROT, S_DRAIN, S_FINW, S_SEEK, S_EMIT
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   term_count_reg;
    logic [CW-1:0]   n_reg, n_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [CW-1:0]   pcnt_reg, pcnt_next;
    logic [CW-1:0]   k_reg, k_next;
    logic [IW-1:0]   t_reg, t_next;
    logic [IW-1:0]   bhead_reg, bhead_next;
    logic [4:0]      bit_reg, bit_next;
    logic [2:0]      inflight_reg, inflight_next;
    logic            step_reg, step_next;
    logic            end_reg, end_next;
    logic [63:0]     coef_reg, coef_next;
    psi_pkg::elem_t  red_reg, red_next;
    psi_pkg::elem_t  acc_reg, acc_next;
    psi_pkg::elem_t  b0_reg, b0_next;
    logic            rv_reg, rv_next;
    psi_pkg::elem_t  rdata_reg, rdata_next;
    logic            rend_reg, rend_next;
    logic            rstat_reg, rstat_next;

    logic            mm_in_valid;
    psi_pkg::elem_t  mm_a, mm_b, mm_c;
    logic            mm_out_valid;
    psi_pkg::elem_t  mm_out;

    psi_pkg::cell_ctl_t ctl;
    psi_pkg::elem_t  tail_a;
    logic            b_wr;
    psi_pkg::elem_t  b_wr_data;
    psi_pkg::elem_t  a_q [MAX_TERMS];
    psi_pkg::elem_t  b_q [MAX_TERMS];

    logic [CW-1:0]   n_eff;
    logic [IW-1:0]   bhead_inc, bhead_dec;
    logic [30:0]     acc_sum;
    logic            keep;
    logic            accept;

    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign n_eff     = (term_count_reg > CW'(MAX_TERMS)) ? CW'(MAX_TERMS) : term_count_reg;
    assign bhead_inc = (bhead_reg == IW'(MAX_TERMS - 1)) ? '0 : bhead_reg + 1'b1;
    assign bhead_dec = (bhead_reg == '0) ? IW'(MAX_TERMS - 1) : bhead_reg - 1'b1;
    assign acc_sum   = {1'b0, acc_reg} + {1'b0, mm_out};
    assign keep      = (cnt_reg < n_reg);

    genvar j;
    generate
        for (j = 0; j < MAX_TERMS; j++)
        begin : g_chain
            psi_cell u_cell
            (
                .clk       (clk),
                .ctl       (ctl),
                .a_in      ((j == MAX_TERMS - 1) ? tail_a : a_q[(j + 1) % MAX_TERMS]),
                .b_fwd_in  (b_q[(j + 1) % MAX_TERMS]),
                .b_bwd_in  (b_q[(j + MAX_TERMS - 1) % MAX_TERMS]),
                .b_wr      ((j == 0) ? b_wr : 1'b0),
                .b_wr_data (b_wr_data),
                .a_out     (a_q[j]),
                .b_out     (b_q[j])
            );
        end
    endgenerate

    psi_mulmod u_mulmod
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mm_in_valid),
        .a         (mm_a),
        .b         (mm_b),
        .c         (mm_c),
        .out_valid (mm_out_valid),
        .result    (mm_out)
    );

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        cnt_next   = cnt_reg;
        pcnt_next  = pcnt_reg;
        k_next     = k_reg;
        t_next     = t_reg;
        bhead_next = bhead_reg;
        bit_next   = bit_reg;
        step_next  = step_reg;
        end_next   = end_reg;
        coef_next  = coef_reg;
        red_next   = red_reg;
        acc_next   = acc_reg;
        b0_next    = b0_reg;
        rv_next    = 1'b0;
        rdata_next = rdata_reg;
        rend_next  = rend_reg;
        rstat_next = rstat_reg;
        mm_in_valid = 1'b0;
        mm_a       = '0;
        mm_b       = '0;
        mm_c       = '0;
        ctl        = '0;
        tail_a     = a_q[0];
        b_wr       = 1'b0;
        b_wr_data  = '0;

        // products of a chain pass accumulate as they come back
        if (mm_out_valid && (state_reg == S_ROT || state_reg == S_DRAIN))
        begin
            acc_next = (acc_sum >= {1'b0, psi_pkg::PRIME})
                ? psi_pkg::DW'(acc_sum - {1'b0, psi_pkg::PRIME})
                : acc_sum[psi_pkg::DW-1:0];
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    coef_next  = coefficient;
                    end_next   = series_end;
                    n_next     = n_eff;
                    step_next  = 1'b0;
                    state_next = S_RED;
                end
            end
            S_RED:
            begin
                mm_in_valid = 1'b1;
                mm_b        = psi_pkg::RADIX_RES;
                if (!step_reg)
                begin
                    mm_a = psi_pkg::DW'(coef_reg[63:60]);
                    mm_c = coef_reg[59:30];
                end
                else
                begin
                    mm_a = red_reg;
                    mm_c = coef_reg[29:0];
                end
                state_next = S_REDW;
            end
            S_REDW:
            begin
                if (mm_out_valid)
                begin
                    red_next   = mm_out;
                    step_next  = 1'b1;
                    state_next = step_reg ? S_LOAD : S_RED;
                end
            end
            S_LOAD:
            begin
                if (keep)
                begin
                    ctl.a_shift = 1'b1;
                    tail_a      = red_reg;
                end
                if (!end_reg)
                begin
                    cnt_next   = cnt_reg + CW'(keep);
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next   = '0;
                    pcnt_next  = cnt_reg + CW'(keep);
                    state_next = (n_reg == '0) ? S_IDLE : S_PAD;
                end
            end
            S_PAD:
            begin
                // zero fill puts a_i in cell i and clears stale entries
                if (pcnt_reg < CW'(MAX_TERMS))
                begin
                    ctl.a_shift = 1'b1;
                    tail_a      = '0;
                    pcnt_next   = pcnt_reg + 1'b1;
                end
                else
                begin
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (a_q[0] == '0)
                begin
                    rv_next    = 1'b1;
                    rdata_next = '0;
                    rend_next  = 1'b1;
                    rstat_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    red_next   = psi_pkg::DW'(1);
                    bit_next   = 5'(psi_pkg::DW - 1);
                    state_next = S_INV_SQ;
                end
            end
            S_INV_SQ:
            begin
                mm_in_valid = 1'b1;
                mm_a        = red_reg;
                mm_b        = red_reg;
                state_next  = S_INV_SQW;
            end
            S_INV_ML:
            begin
                mm_in_valid = 1'b1;
                mm_a        = red_reg;
                mm_b        = a_q[0];
                state_next  = S_INV_MLW;
            end
            S_INV_SQW,
            S_INV_MLW:
            begin
                if (mm_out_valid)
                begin
                    red_next = mm_out;
                    if (state_reg == S_INV_SQW && psi_pkg::INV_EXP[bit_reg])
                    begin
                        state_next = S_INV_ML;
                    end
                    else if (bit_reg != '0)
                    begin
                        bit_next   = bit_reg - 1'b1;
                        state_next = S_INV_SQ;
                    end
                    else
                    begin
                        b0_next    = mm_out;
                        b_wr       = 1'b1;
                        b_wr_data  = mm_out;
                        bhead_next = '0;
                        k_next     = CW'(1);
                        state_next = (n_reg == CW'(1)) ? S_SEEK : S_ALIGN;
                    end
                end
            end
            S_ALIGN:
            begin
                ctl.b_fwd  = 1'b1;
                bhead_next = bhead_inc;
                acc_next   = '0;
                t_next     = '0;
                state_next = S_ROT;
            end
            S_ROT:
            begin
                // a_t meets b_(k-t) at the head of the chain
                if (t_reg != '0 && CW'(t_reg) <= k_reg)
                begin
                    mm_in_valid = 1'b1;
                    mm_a        = a_q[0];
                    mm_b        = b_q[0];
                end
                ctl.a_shift = 1'b1;
                ctl.b_bwd   = 1'b1;
                bhead_next  = bhead_dec;
                t_next      = t_reg + 1'b1;
                if (t_reg == IW'(MAX_TERMS - 1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (inflight_reg == '0)
                begin
                    mm_in_valid = 1'b1;
                    mm_a        = acc_reg;
                    mm_b        = b0_reg;
                    state_next  = S_FINW;
                end
            end
            S_FINW:
            begin
                if (mm_out_valid)
                begin
                    b_wr       = 1'b1;
                    b_wr_data  = (mm_out == '0) ? '0 : psi_pkg::PRIME - mm_out;
                    k_next     = k_reg + 1'b1;
                    state_next = (k_reg + 1'b1 == n_reg) ? S_SEEK : S_ALIGN;
                end
            end
            S_SEEK:
            begin
                if (bhead_reg == '0)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    ctl.b_fwd  = 1'b1;
                    bhead_next = bhead_inc;
                end
            end
            S_EMIT:
            begin
                rv_next    = 1'b1;
                rdata_next = b_q[0];
                rend_next  = (CW'(bhead_reg) == n_reg - 1'b1);
                rstat_next = 1'b0;
                ctl.b_fwd  = 1'b1;
                bhead_next = bhead_inc;
                if (CW'(bhead_reg) == n_reg - 1'b1)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        inflight_next = inflight_reg + 3'(mm_in_valid) - 3'(mm_out_valid);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            term_count_reg <= CW'(1);
            cnt_reg        <= '0;
            inflight_reg   <= '0;
            rv_reg         <= 1'b0;
            rdata_reg      <= '0;
            rend_reg       <= 1'b0;
            rstat_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            inflight_reg <= inflight_next;
            rv_reg       <= rv_next;
            rdata_reg    <= rdata_next;
            rend_reg     <= rend_next;
            rstat_reg    <= rstat_next;
            if (cfg_valid && cfg_ready)
            begin
                term_count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        pcnt_reg  <= pcnt_next;
        k_reg     <= k_next;
        t_reg     <= t_next;
        bhead_reg <= bhead_next;
        bit_reg   <= bit_next;
        step_reg  <= step_next;
        end_reg   <= end_next;
        coef_reg  <= coef_next;
        red_reg   <= red_next;
        acc_reg   <= acc_next;
        b0_reg    <= b0_next;
    end

    assign result_valid        = rv_reg;
    assign inverse_coefficient = rdata_reg;
    assign run_end             = rend_reg;
    assign status              = rstat_reg;

endmodule

@@ tb/sv/power_series_inverse_mod_prime_core_tb.sv @@
`timescale 1ns / 1ps
// testbench for power_series_inverse_mod_prime_core: streams power series with random
// term counts and compares each reciprocal coefficient against an in-bench recurrence
// depends on psi_pkg and the core
module power_series_inverse_mod_prime_core_tb;

    localparam int unsigned MAXT = 64;
    localparam longint unsigned P = 64'd998244353;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [63:0] coef;
        logic        last;
    } coef_item_t;

    typedef struct packed {
        psi_pkg::elem_t value;
        logic           last;
        logic           err;
    } inv_coef_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [63:0] coefficient;
    logic        series_end;
    logic        result_valid;
    logic [29:0] inverse_coefficient;
    logic        run_end;
    logic        status;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [6:0]  cfg_data;

    power_series_inverse_mod_prime_core dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .coefficient(coefficient), .series_end(series_end),
        .result_valid(result_valid), .inverse_coefficient(inverse_coefficient),
        .run_end(run_end), .status(status),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    coef_item_t  pending_q[$];
    inv_coef_t   expected_q[$];
    int          fail_count;
    int          idle_cycles;
    int          burst_left;
    int          gap_left;
    int          accepted_count;

    // predictor state
    logic [6:0]     term_count_m;
    psi_pkg::elem_t kept_coef[MAXT];
    int unsigned    kept_count;
    psi_pkg::elem_t inv_coef[MAXT];

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic psi_pkg::elem_t mul_p(psi_pkg::elem_t a, psi_pkg::elem_t b);
        longint unsigned prod;
        prod = 64'(a) * 64'(b);
        return psi_pkg::elem_t'(prod % P);
    endfunction

    function automatic psi_pkg::elem_t pow_p(psi_pkg::elem_t base, psi_pkg::elem_t e);
        psi_pkg::elem_t r;
        r = 30'd1;
        while (e != 0)
        begin
            if (e[0])
                r = mul_p(r, base);
            base = mul_p(base, base);
            e = e >> 1;
        end
        return r;
    endfunction

    function automatic psi_pkg::elem_t coef_at(int unsigned i);
        if (i < kept_count)
            return kept_coef[i];
        return '0;
    endfunction

    // records one accepted coefficient and, at a series end, runs the reciprocal recurrence
    task automatic predict_inverse(coef_item_t it);
        int unsigned n;
        psi_pkg::elem_t c;
        psi_pkg::elem_t b0;
        longint unsigned acc;
        inv_coef_t r;
        n = (term_count_m > MAXT) ? MAXT : term_count_m;
        c = psi_pkg::elem_t'(it.coef % P);
        if (kept_count < n)
        begin
            kept_coef[kept_count] = c;
            kept_count++;
        end
        if (!it.last)
            return;
        if (n == 0)
        begin
            kept_count = 0;
            return;
        end
        if (coef_at(0) == 0)
        begin
            r.value = '0;
            r.last = 1'b1;
            r.err = 1'b1;
            expected_q.push_back(r);
            kept_count = 0;
            return;
        end
        b0 = pow_p(coef_at(0), psi_pkg::elem_t'(P - 2));
        inv_coef[0] = b0;
        for (int unsigned k = 1; k < n; k++)
        begin
            acc = 0;
            for (int unsigned i = 1; i <= k; i++)
                acc = (acc + 64'(mul_p(coef_at(i), inv_coef[k - i]))) % P;
            acc = 64'(mul_p(psi_pkg::elem_t'(acc), b0));
            inv_coef[k] = (acc == 0) ? '0 : psi_pkg::elem_t'(P - acc);
        end
        for (int unsigned k = 0; k < n; k++)
        begin
            r.value = inv_coef[k];
            r.last = (k + 1 == n);
            r.err = 1'b0;
            expected_q.push_back(r);
        end
        kept_count = 0;
    endtask

    // driver: bursts and gaps, start held across back-to-back transactions
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            coefficient <= '0;
            series_end <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                predict_inverse(coef_item_t'{coef: coefficient, last: series_end});
                accepted_count <= accepted_count + 1;
            end
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    start <= 1'b0;
                end
                else if (pending_q.size() > 0)
                begin
                    coef_item_t it;
                    it = pending_q.pop_front();
                    start <= 1'b1;
                    coefficient <= it.coef;
                    series_end <= it.last;
                    if (burst_left == 0)
                    begin
                        burst_left <= $urandom_range(1, 8);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor: results cannot be stalled, so check every strobe
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (expected_q.size() == 0)
            begin
                $error("unexpected result inverse_coefficient=%0d", inverse_coefficient);
                fail_count++;
            end
            else
            begin
                inv_coef_t e;
                e = expected_q.pop_front();
                if (inverse_coefficient !== e.value)
                begin
                    $error("inverse_coefficient expected %0d got %0d", e.value,
                           inverse_coefficient);
                    fail_count++;
                end
                if (run_end !== e.last)
                begin
                    $error("run_end expected %0d got %0d", e.last, run_end);
                    fail_count++;
                end
                if (status !== e.err)
                begin
                    $error("status expected %0d got %0d", e.err, status);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [63:0] rand_coef();
        case ($urandom_range(0, 5))
            0: return {$urandom, $urandom};
            1: return 64'(P) * $urandom_range(0, 3);
            2: return 64'hFFFF_FFFF_FFFF_FFFF;
            default: return 64'($urandom_range(0, 998244352));
        endcase
    endfunction

    task automatic push_series(int unsigned len, bit zero_a0);
        coef_item_t it;
        for (int unsigned i = 0; i < len; i++)
        begin
            it.coef = (i == 0 && zero_a0) ? 64'(P) * $urandom_range(0, 2) : rand_coef();
            it.last = (i + 1 == len);
            pending_q.push_back(it);
        end
    endtask

    // waits for the block to drain, then writes term_count
    task automatic write_term_count(logic [6:0] v);
        wait (pending_q.size() == 0);
        @(posedge clk);
        while (start || expected_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        term_count_m = v;
        @(posedge clk);
    endtask

    initial
    begin
        logic [6:0] tc;
        int unsigned len;
        fail_count = 0;
        accepted_count = 0;
        kept_count = 0;
        term_count_m = 7'd1;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset count, zero, extremes, zero constant term, overlong
        push_series(1, 0);
        push_series(2, 1);
        write_term_count(7'd0);
        push_series(2, 0);
        write_term_count(7'd127);
        push_series(3, 0);
        pending_q.push_back(coef_item_t'{coef: 64'hFFFF_FFFF_FFFF_FFFF, last: 1'b1});
        write_term_count(7'd64);
        push_series(1, 1);
        push_series(5, 0);
        write_term_count(7'd3);
        push_series(6, 0);
        push_series(2, 1);

        // random phases: mostly small term counts, a few large
        for (int ph = 0; ph < 10; ph++)
        begin
            case ($urandom_range(0, 5))
                0: tc = 7'($urandom_range(40, 127));
                1: tc = 7'($urandom_range(0, 1));
                default: tc = 7'($urandom_range(2, 12));
            endcase
            write_term_count(tc);
            for (int s = 0; s < 6; s++)
            begin
                len = $urandom_range(1, (tc > 12 ? 12 : tc) + 2);
                push_series(len, $urandom_range(0, 9) == 0);
            end
        end

        write_term_count(7'd64);
        wait (pending_q.size() == 0);
        @(posedge clk);
        while (start || expected_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0 && expected_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
